// File: design/cma_pkg.sv
// Shared constants, types and the helper function of the contiguous memory allocator.
package cma_pkg;

   localparam int MEM_UNITS  = 1024;
   localparam int UNIT_W     = $clog2(MEM_UNITS);
   localparam int SIZE_W     = UNIT_W + 1;
   localparam int WORD_BITS  = 16;
   localparam int WORD_SEL_W = $clog2(WORD_BITS);
   localparam int WORDS      = MEM_UNITS / WORD_BITS;
   localparam int WORD_AW    = $clog2(WORDS);
   localparam int MAX_OWNERS = 256;
   localparam int OWNER_W    = $clog2(MAX_OWNERS);
   localparam int MODE_W     = 2;

   localparam logic [MODE_W-1:0] MODE_FIRST_FIT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NEXT_FIT  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_BUDDY     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SPARE     = 2'd3;
   localparam logic              KIND_ALLOC     = 1'b0;
   localparam logic              KIND_FREE      = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_OWNER,
      ST_SCAN,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic              hit;
      logic [SIZE_W-1:0] run;
      logic [UNIT_W-1:0] unit;
   } eval_type;

   function automatic logic [SIZE_W-1:0] pow2_ceil(input logic [SIZE_W-1:0] size);
      logic [SIZE_W-1:0] r;
      r = '0;
      for (int i = SIZE_W - 1; i >= 0; i--) begin
         if ((SIZE_W'(1) << i) >= size) begin
            r = SIZE_W'(1) << i;
         end
      end
      return r;
   endfunction

endpackage

// File: design/cma_channels.sv
// Request and response channel interfaces of the allocator.
interface cma_req_if;
   logic                          valid;
   logic                          ready;
   logic                          kind;
   logic [cma_pkg::OWNER_W-1:0]   owner_id;
   logic [cma_pkg::SIZE_W-1:0]    request_size;
   modport source (output valid, kind, owner_id, request_size, input ready);
   modport sink (input valid, kind, owner_id, request_size, output ready);
endinterface

interface cma_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          ok;
   logic [cma_pkg::UNIT_W-1:0]    block_start;
   logic [cma_pkg::UNIT_W-1:0]    block_end;
   modport source (output valid, ok, block_start, block_end, input ready);
   modport sink (input valid, ok, block_start, block_end, output ready);
endinterface

// File: design/cma_ram.sv
// Generic single write port, single read port RAM with registered read data.
module cma_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: design/cma_word_eval.sv
// Free-run tracking over one word of the occupancy map.
module cma_word_eval (
   input  logic [cma_pkg::WORD_BITS-1:0] blk,
   input  logic [cma_pkg::WORD_AW-1:0]   word,
   input  logic [cma_pkg::SIZE_W-1:0]    run_in,
   input  logic [cma_pkg::SIZE_W-1:0]    len,
   input  logic                          buddy,
   output cma_pkg::eval_type             result
);

   logic [cma_pkg::UNIT_W-1:0] lenm1;

   assign lenm1 = cma_pkg::UNIT_W'(len - cma_pkg::SIZE_W'(1));

   always_comb begin
      logic [cma_pkg::UNIT_W-1:0] u;
      logic [cma_pkg::SIZE_W-1:0] run;
      logic                       hit;
      logic [cma_pkg::UNIT_W-1:0] unit;
      run  = run_in;
      hit  = 1'b0;
      unit = '0;
      for (int j = 0; j < cma_pkg::WORD_BITS; j++) begin
         u = {word, cma_pkg::WORD_SEL_W'(j)};
         if (!hit) begin
            if (blk[j]) begin
               run = '0;
            end else if (buddy && ((u & lenm1) == '0)) begin
               run = cma_pkg::SIZE_W'(1);
            end else begin
               run = run + cma_pkg::SIZE_W'(1);
            end
            if (run == len) begin
               hit  = 1'b1;
               unit = u;
            end
         end
      end
      result.hit  = hit;
      result.run  = run;
      result.unit = unit;
   end

endmodule

// File: design/contiguous_memory_allocator_core.sv
// Top level of the contiguous memory allocator with its control sequencer.
// A free of a held block reads the owner table and then reads and rewrites each map word
// the block covers; an allocate first searches the 16-unit map words for a hole (at most 64
// words, or 128 for a next fit that wraps) and then marks the map words the block covers.
// One request is handled at a time; the search rate is set by the single map read port.
// Reset is synchronous and clears the map row flags, owner flags, rover and mode.
module contiguous_memory_allocator_core (
   input  logic                        clock,
   input  logic                        reset,
   cma_req_if.sink                     req_if,
   cma_rsp_if.source                   rsp_if,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready
);

   localparam int UW = cma_pkg::UNIT_W;
   localparam int SW = cma_pkg::SIZE_W;
   localparam int AW = cma_pkg::WORD_AW;
   localparam int WB = cma_pkg::WORD_BITS;
   localparam int OW = cma_pkg::OWNER_W;

   cma_pkg::state_type state_ff, state_in;

   logic [cma_pkg::MODE_W-1:0] mode_ff, mode_in;
   logic [UW-1:0]              rover_ff, rover_in;
   logic [cma_pkg::WORDS-1:0]  rowv_ff, rowv_in;
   logic [cma_pkg::MAX_OWNERS-1:0] ownv_ff, ownv_in;
   logic                       kind_ff, kind_in;
   logic [OW-1:0]              id_ff, id_in;
   logic [SW-1:0]              len_ff, len_in;
   logic [AW-1:0]              cur_ff, cur_in;
   logic [SW-1:0]              run_ff, run_in;
   logic                       pass1_ff, pass1_in;
   logic [UW-1:0]              s_ff, s_in;
   logic [UW-1:0]              e_ff, e_in;
   logic [AW-1:0]              mkw_ff, mkw_in;
   logic                       res_ok_ff, res_ok_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       rsp_ok_ff, rsp_ok_in;
   logic [UW-1:0]              rsp_s_ff, rsp_s_in;
   logic [UW-1:0]              rsp_e_ff, rsp_e_in;

   logic                       occ_we;
   logic [AW-1:0]              occ_raddr;
   logic [WB-1:0]              occ_wdata, occ_q, occ_data, force_mask, wmask;
   logic                       own_we;
   logic [OW-1:0]              own_raddr;
   logic [2*UW-1:0]            own_q;
   logic                       next_fit, buddy;
   logic [SW-1:0]              hit_start;
   cma_pkg::eval_type          ev;

   cma_ram #(.WIDTH(WB), .DEPTH(cma_pkg::WORDS)) u_occ_ram (
      .clock (clock),
      .we    (occ_we),
      .waddr (mkw_ff),
      .wdata (occ_wdata),
      .raddr (occ_raddr),
      .rdata (occ_q)
   );

   cma_ram #(.WIDTH(2*UW), .DEPTH(cma_pkg::MAX_OWNERS)) u_owner_ram (
      .clock (clock),
      .we    (own_we),
      .waddr (id_ff),
      .wdata ({s_ff, e_ff}),
      .raddr (own_raddr),
      .rdata (own_q)
   );

   assign next_fit = (mode_ff == cma_pkg::MODE_NEXT_FIT);
   assign buddy    = (mode_ff == cma_pkg::MODE_BUDDY);
   assign occ_data = rowv_ff[cur_ff] ? occ_q : '0;

   always_comb begin
      force_mask = '0;
      if (next_fit && pass1_ff && (cur_ff == rover_ff[UW-1 -: AW])) begin
         for (int j = 0; j < WB; j++) begin
            force_mask[j] = (cma_pkg::WORD_SEL_W'(j) < rover_ff[cma_pkg::WORD_SEL_W-1:0]);
         end
      end
   end

   cma_word_eval u_eval (
      .blk    (occ_data | force_mask),
      .word   (cur_ff),
      .run_in (run_ff),
      .len    (len_ff),
      .buddy  (buddy),
      .result (ev)
   );

   assign hit_start = SW'(ev.unit) + SW'(1) - len_ff;

   always_comb begin
      logic [UW-1:0] u;
      for (int j = 0; j < WB; j++) begin
         u = {mkw_ff, cma_pkg::WORD_SEL_W'(j)};
         wmask[j] = (u >= s_ff) && (u <= e_ff);
      end
   end

   always_comb begin
      logic [WB-1:0] old;
      old       = rowv_ff[mkw_ff] ? occ_q : '0;
      occ_wdata = kind_ff ? (old & ~wmask) : (old | wmask);
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      rover_in     = rover_ff;
      rowv_in      = rowv_ff;
      ownv_in      = ownv_ff;
      kind_in      = kind_ff;
      id_in        = id_ff;
      len_in       = len_ff;
      cur_in       = cur_ff;
      run_in       = run_ff;
      pass1_in     = pass1_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      mkw_in       = mkw_ff;
      res_ok_in    = res_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_s_in     = rsp_s_ff;
      rsp_e_in     = rsp_e_ff;
      occ_we       = 1'b0;
      own_we       = 1'b0;
      occ_raddr    = cur_ff + AW'(1);
      own_raddr    = req_if.owner_id;
      req_if.ready = (state_ff == cma_pkg::ST_IDLE);

      if (csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]) begin
         mode_in = csr_pwdata[cma_pkg::MODE_W-1:0];
      end

      case (state_ff)
         cma_pkg::ST_IDLE: begin
            if (req_if.valid) begin
               kind_in   = req_if.kind;
               id_in     = req_if.owner_id;
               res_ok_in = 1'b0;
               s_in      = '0;
               e_in      = '0;
               run_in    = '0;
               pass1_in  = 1'b1;
               cur_in    = next_fit ? rover_ff[UW-1 -: AW] : '0;
               occ_raddr = cur_in;
               len_in    = buddy ? cma_pkg::pow2_ceil(req_if.request_size)
                                 : req_if.request_size;
               if (req_if.kind == cma_pkg::KIND_FREE) begin
                  state_in = ownv_ff[req_if.owner_id] ? cma_pkg::ST_OWNER
                                                      : cma_pkg::ST_RESULT;
               end else if (ownv_ff[req_if.owner_id] || (req_if.request_size == '0) ||
                            (req_if.request_size > SW'(cma_pkg::MEM_UNITS))) begin
                  state_in = cma_pkg::ST_RESULT;
               end else begin
                  state_in = cma_pkg::ST_SCAN;
               end
            end
         end
         cma_pkg::ST_OWNER: begin
            s_in     = own_q[2*UW-1:UW];
            e_in     = own_q[UW-1:0];
            mkw_in   = own_q[2*UW-1 -: AW];
            state_in = cma_pkg::ST_MARK_RD;
         end
         cma_pkg::ST_SCAN: begin
            if (ev.hit) begin
               s_in     = hit_start[UW-1:0];
               e_in     = ev.unit;
               mkw_in   = hit_start[UW-1 -: AW];
               state_in = cma_pkg::ST_MARK_RD;
            end else if (cur_ff == AW'(cma_pkg::WORDS - 1)) begin
               if (next_fit && pass1_ff) begin
                  pass1_in = 1'b0;
                  cur_in   = '0;
                  run_in   = '0;
               end else begin
                  state_in = cma_pkg::ST_RESULT;
               end
            end else begin
               cur_in = cur_ff + AW'(1);
               run_in = ev.run;
            end
         end
         cma_pkg::ST_MARK_RD: begin
            occ_raddr = mkw_ff;
            state_in  = cma_pkg::ST_MARK_WR;
         end
         cma_pkg::ST_MARK_WR: begin
            occ_we          = 1'b1;
            rowv_in[mkw_ff] = 1'b1;
            if (mkw_ff == e_ff[UW-1 -: AW]) begin
               res_ok_in = 1'b1;
               state_in  = cma_pkg::ST_RESULT;
               if (kind_ff == cma_pkg::KIND_FREE) begin
                  ownv_in[id_ff] = 1'b0;
               end else begin
                  own_we         = 1'b1;
                  ownv_in[id_ff] = 1'b1;
                  rover_in       = e_ff + UW'(1);
               end
            end else begin
               mkw_in   = mkw_ff + AW'(1);
               state_in = cma_pkg::ST_MARK_RD;
            end
         end
         cma_pkg::ST_RESULT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = res_ok_ff;
               rsp_s_in     = res_ok_ff ? s_ff : '0;
               rsp_e_in     = res_ok_ff ? e_ff : '0;
               state_in     = cma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cma_pkg::ST_IDLE;
         mode_ff      <= '0;
         rover_ff     <= '0;
         rowv_ff      <= '0;
         ownv_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         rover_ff     <= rover_in;
         rowv_ff      <= rowv_in;
         ownv_ff      <= ownv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      id_ff     <= id_in;
      len_ff    <= len_in;
      cur_ff    <= cur_in;
      run_ff    <= run_in;
      pass1_ff  <= pass1_in;
      s_ff      <= s_in;
      e_ff      <= e_in;
      mkw_ff    <= mkw_in;
      res_ok_ff <= res_ok_in;
      rsp_ok_ff <= rsp_ok_in;
      rsp_s_ff  <= rsp_s_in;
      rsp_e_ff  <= rsp_e_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.ok          = rsp_ok_ff;
   assign rsp_if.block_start = rsp_s_ff;
   assign rsp_if.block_end   = rsp_e_ff;

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {{(32 - cma_pkg::MODE_W){1'b0}}, mode_ff};

`ifndef SYNTHESIS
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && !rsp_if.ok |-> rsp_if.block_start == '0 && rsp_if.block_end == '0)
      else $error("failed transfer carries non-zero bounds");

   a_ok_order: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && rsp_if.ok |-> rsp_if.block_end >= rsp_if.block_start)
      else $error("block end lies below block start");

   a_one_at_once: assert property (@(posedge clock) disable iff (reset)
      req_if.valid && req_if.ready |=> !req_if.ready)
      else $error("request taken while another is in progress");
`endif

endmodule

// File: tb/sv/contiguous_memory_allocator_core_tb.sv
// Randomised self-checking testbench of the contiguous memory allocator core.
`timescale 1ns / 1ps

class alloc_scoreboard;
   bit        used_map [1024];
   bit        holds [256];
   bit [9:0]  held_start [256];
   bit [9:0]  held_end [256];
   bit [9:0]  rover;
   bit [1:0]  mode;
   bit        want_ok [$];
   bit [9:0]  want_start [$];
   bit [9:0]  want_end [$];
   int        errors;
   int        checked;
   int        ok_count;

   function void clear();
      foreach (used_map[i]) used_map[i] = 0;
      foreach (holds[i]) holds[i] = 0;
      rover = 0;
      mode = 0;
   endfunction

   function int hole_from(int from, int len);
      int run;
      run = 0;
      for (int u = from; u < 1024; u++) begin
         if (used_map[u]) begin
            run = 0;
         end else begin
            run++;
            if (run == len) return u + 1 - len;
         end
      end
      return -1;
   endfunction

   function void note_request(bit kind, bit [7:0] id, bit [10:0] size);
      bit ok;
      int s, e, pos, len, b;
      bit free_span;
      ok = 0; s = 0; e = 0; pos = -1; len = size;
      if (kind == cma_pkg::KIND_FREE) begin
         if (holds[id]) begin
            s = held_start[id]; e = held_end[id];
            for (int u = s; u <= e; u++) used_map[u] = 0;
            holds[id] = 0;
            ok = 1;
         end
      end else if (!holds[id] && size != 0 && size <= 1024) begin
         if (mode == cma_pkg::MODE_NEXT_FIT) begin
            pos = hole_from(rover, len);
            if (pos < 0) pos = hole_from(0, len);
         end else if (mode == cma_pkg::MODE_BUDDY) begin
            b = 1;
            while (b < size) b = b << 1;
            len = b;
            for (int a = 0; a + b <= 1024 && pos < 0; a += b) begin
               free_span = 1;
               for (int u = a; u < a + b; u++) if (used_map[u]) free_span = 0;
               if (free_span) pos = a;
            end
         end else begin
            pos = hole_from(0, len);
         end
         if (pos >= 0) begin
            s = pos; e = pos + len - 1;
            for (int u = s; u <= e; u++) used_map[u] = 1;
            held_start[id] = 10'(s); held_end[id] = 10'(e); holds[id] = 1;
            rover = 10'((e + 1 >= 1024) ? 0 : e + 1);
            ok = 1;
         end
      end
      if (!ok) begin s = 0; e = 0; end
      want_ok.push_back(ok);
      want_start.push_back(10'(s));
      want_end.push_back(10'(e));
   endfunction

   function void check_result(bit ok, bit [9:0] s, bit [9:0] e);
      bit xo;
      bit [9:0] xs, xe;
      if (want_ok.size() == 0) begin
         $display("%0t: unexpected result ok=%0d start=%0d end=%0d", $time, ok, s, e);
         errors++;
         return;
      end
      xo = want_ok.pop_front(); xs = want_start.pop_front(); xe = want_end.pop_front();
      checked++;
      if (ok) ok_count++;
      if (xo !== ok) begin
         $display("%0t: ok expected %0d actual %0d", $time, xo, ok); errors++;
      end
      if (xs !== s) begin
         $display("%0t: block_start expected %0d actual %0d", $time, xs, s); errors++;
      end
      if (xe !== e) begin
         $display("%0t: block_end expected %0d actual %0d", $time, xe, e); errors++;
      end
   endfunction
endclass

module contiguous_memory_allocator_core_tb;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [2:0]  csr_paddr = 0;
   logic [31:0] csr_pwdata = 0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   longint      cycles = 0;
   int          sent = 0;
   alloc_scoreboard board;

   cma_req_if req_if ();
   cma_rsp_if rsp_if ();

   contiguous_memory_allocator_core uut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always #5 clock = ~clock;

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 150);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 6000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         board.check_result(rsp_if.ok, rsp_if.block_start, rsp_if.block_end);
   end

   initial begin : sink_side
      int g;
      g = 0;
      rsp_if.ready = 0;
      forever begin
         @(negedge clock);
         if (g > 0) begin
            g--;
            rsp_if.ready <= 0;
         end else begin
            rsp_if.ready <= 1;
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
         end
      end
   end

   task automatic write_mode(input bit [1:0] m);
      @(negedge clock);
      csr_psel <= 1; csr_penable <= 0; csr_pwrite <= 1; csr_paddr <= 3'd0;
      csr_pwdata <= {30'd0, m};
      @(negedge clock);
      csr_penable <= 1;
      @(negedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      board.mode = m;
   endtask

   task automatic send(input bit kind, input bit [7:0] id, input bit [10:0] size);
      int g;
      g = gap_len();
      if ($urandom_range(0, 2) == 0) g = 0;
      repeat (g) begin
         @(negedge clock);
         req_if.valid <= 0;
      end
      @(negedge clock);
      req_if.valid <= 1; req_if.kind <= kind; req_if.owner_id <= id;
      req_if.request_size <= size;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      board.note_request(kind, id, size);
      sent++;
      @(negedge clock);
      req_if.valid <= 0;
   endtask

   task automatic drain();
      while (board.want_ok.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic bit [10:0] pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 11'($urandom_range(1, 40));
      if (r < 85) return 11'($urandom_range(1, 300));
      if (r < 95) return 11'($urandom_range(0, 1024));
      return 11'($urandom_range(0, 2047));
   endfunction

   initial begin
      bit [1:0] modes [6];
      req_if.valid = 0; req_if.kind = 0; req_if.owner_id = 0; req_if.request_size = 0;
      board = new();
      board.clear();
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // Directed: zero size, too large, whole memory, allocate when full, unknown free.
      send(cma_pkg::KIND_ALLOC, 8'd0, 11'd0);
      send(cma_pkg::KIND_ALLOC, 8'd1, 11'd1025);
      send(cma_pkg::KIND_ALLOC, 8'd2, 11'd2047);
      send(cma_pkg::KIND_ALLOC, 8'd255, 11'd1024);
      send(cma_pkg::KIND_ALLOC, 8'd3, 11'd1);
      send(cma_pkg::KIND_FREE, 8'd255, 11'd0);
      send(cma_pkg::KIND_ALLOC, 8'd3, 11'd1);
      send(cma_pkg::KIND_FREE, 8'd7, 11'd5);
      send(cma_pkg::KIND_ALLOC, 8'd4, 11'd10);
      send(cma_pkg::KIND_ALLOC, 8'd5, 11'd20);
      send(cma_pkg::KIND_FREE, 8'd4, 11'd0);
      send(cma_pkg::KIND_ALLOC, 8'd6, 11'd5);
      drain();
      write_mode(cma_pkg::MODE_NEXT_FIT);
      send(cma_pkg::KIND_ALLOC, 8'd7, 11'd1000);
      send(cma_pkg::KIND_ALLOC, 8'd8, 11'd3);
      send(cma_pkg::KIND_FREE, 8'd5, 11'd0);
      send(cma_pkg::KIND_ALLOC, 8'd9, 11'd20);
      drain();
      write_mode(cma_pkg::MODE_BUDDY);
      send(cma_pkg::KIND_ALLOC, 8'd10, 11'd3);
      send(cma_pkg::KIND_ALLOC, 8'd11, 11'd513);
      send(cma_pkg::KIND_ALLOC, 8'd12, 11'd17);
      drain();
      write_mode(cma_pkg::MODE_SPARE);
      send(cma_pkg::KIND_ALLOC, 8'd13, 11'd2);
      send(cma_pkg::KIND_ALLOC, 8'd14, 11'd1023);
      drain();
      modes = '{cma_pkg::MODE_FIRST_FIT, cma_pkg::MODE_NEXT_FIT, cma_pkg::MODE_BUDDY,
                cma_pkg::MODE_SPARE, cma_pkg::MODE_NEXT_FIT, cma_pkg::MODE_BUDDY};
      foreach (modes[p]) begin
         write_mode(modes[p]);
         repeat (250) begin
            bit [7:0] id;
            id = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 31));
            if ($urandom_range(0, 1)) send(cma_pkg::KIND_ALLOC, id, pick_size());
            else send(cma_pkg::KIND_FREE, id, 11'($urandom_range(0, 2047)));
         end
         drain();
      end
      $display("Covered %0d requests, %0d results checked, %0d successful,", sent,
               board.checked, board.ok_count);
      $display("across first fit, next fit, buddy and the spare mode.");
      if (board.errors == 0 && board.want_ok.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end
endmodule
